### rtl/assert_macros.svh
// assertion macros for the rtl file that checks its own behavior
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define ASSERT_DEF(label, prop) `ASSERT_CLK(label, clk_i, rst_ni, prop)
`else
`define ASSERT_CLK(label, clk, rstn, prop)
`define ASSERT_DEF(label, prop)
`endif
`endif

### rtl/fps_pkg.sv
// shared types, codes and constants of the farthest point sampler
package fps_pkg;

  localparam int MAX_POINTS_DEF = 4096;
  localparam int COORD_BITS_DEF = 16;

  localparam int SAMPLE_W    = 13;
  localparam int START_W     = 12;
  localparam int INDEX_OUT_W = 12;
  localparam int OUT_COORD_W = 16;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 13;

  localparam logic [SAMPLE_W-1:0] SAMPLE_COUNT_RST = 13'd1024;
  localparam logic [START_W-1:0]  START_INDEX_RST  = 12'd0;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_DONE  = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_COUNT = 1'b0,
    CFG_START_INDEX  = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    REQ_LOAD   = 1'b0,
    REQ_SAMPLE = 1'b1
  } req_e;

  typedef struct packed {
    logic load;
    logic emit_err;
    logic take_direct;
    logic rd_last;
    logic lp_load;
    logic sweep_start;
    logic pick_best;
    logic rd_pick;
    logic emit_pick;
  } cmd_t;

  typedef struct packed {
    logic req_empty;
    logic req_exhausted;
    logic req_direct;
    logic sweep_done;
  } stat_t;

endpackage

### rtl/fps_ram.sv
// generic single write port ram with registered read
module fps_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/fps_datapath.sv
// datapath: point and distance stores, counters, distance pipeline and result registers
module fps_datapath import fps_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cmd_t                          cmd_i,
  output stat_t                         stat_o,
  input  logic                          new_set_i,
  input  logic signed [COORD_BITS-1:0]  pos_x_i,
  input  logic signed [COORD_BITS-1:0]  pos_y_i,
  input  logic signed [COORD_BITS-1:0]  pos_z_i,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata_i,
  output logic                          valid_o,
  output logic [INDEX_OUT_W-1:0]        point_index_o,
  output logic signed [OUT_COORD_W-1:0] out_x_o,
  output logic signed [OUT_COORD_W-1:0] out_y_o,
  output logic signed [OUT_COORD_W-1:0] out_z_o,
  output logic                          last_sample_o,
  output logic [STATUS_W-1:0]           status_o,
  output logic                          overflowed_o
);

  localparam int C    = COORD_BITS;
  localparam int IW   = $clog2(MAX_POINTS);
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int CMPW = (CW > SAMPLE_W) ? CW : SAMPLE_W;
  localparam int PW   = 3 * C;
  localparam int DW   = 2 * C + 2;
  localparam int OIW  = (IW > INDEX_OUT_W) ? IW : INDEX_OUT_W;

  // configuration and bookkeeping
  logic [SAMPLE_W-1:0] sample_count_q;
  logic [START_W-1:0]  start_index_q;
  logic [CW-1:0]       point_total_q;
  logic [CW-1:0]       picked_total_q;
  logic [IW-1:0]       last_picked_q;
  logic                overflow_q;
  logic [IW-1:0]       pick_q;

  // sweep control
  logic [CW-1:0] scan_q;
  logic          issuing_q;
  logic          rd_v_q, s1_v_q, s2_v_q, s3_v_q, s4_v_q;

  // sweep payload
  logic [IW-1:0]   rd_idx_q, s1_idx_q, s2_idx_q, s3_idx_q, s4_idx_q;
  logic [PW-1:0]   lp_q;
  logic [C-1:0]    ad_q [3];
  logic [2*C-1:0]  sq_q [3];
  logic [DW-1:0]   s1_min_q, s2_min_q, s3_min_q;
  logic [DW-1:0]   dist_q;
  logic [DW-1:0]   nmin_q;
  logic [DW-1:0]   best_q;
  logic [IW-1:0]   best_idx_q;

  // result registers
  logic                   valid_q;
  logic [INDEX_OUT_W-1:0] index_q;
  logic [OUT_COORD_W-1:0] ox_q, oy_q, oz_q;
  logic                   last_q;
  logic [STATUS_W-1:0]    status_q;
  logic                   ovf_q;

  // memories
  logic          pt_we;
  logic [IW-1:0] pt_waddr;
  logic [PW-1:0] pt_wdata;
  logic [IW-1:0] raddr;
  logic [PW-1:0] pt_rdata;
  logic [DW-1:0] min_rdata;
  logic [DW-1:0] nmin_d;

  // request decode
  logic [CMPW-1:0] tot_e, want_e, run_e, pk_e, st_e;
  logic            full;
  logic            seq_mode;
  logic [IW-1:0]   direct_pick;
  logic            is_last;

  logic [C-1:0]           ad_d [3];
  logic [2*C-1:0]         sq_d [3];
  logic [DW-1:0]          dist_d;
  logic [OUT_COORD_W-1:0] oc [3];

  assign full     = (point_total_q == CW'(MAX_POINTS));
  assign pt_we    = cmd_i.load && (new_set_i || !full);
  assign pt_waddr = new_set_i ? '0 : point_total_q[IW-1:0];
  assign pt_wdata = {pos_z_i, pos_y_i, pos_x_i};

  assign raddr = issuing_q ? scan_q[IW-1:0] : (cmd_i.rd_last ? last_picked_q : pick_q);

  fps_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_point_ram (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .waddr_i (pt_waddr),
    .wdata_i (pt_wdata),
    .raddr_i (raddr),
    .rdata_o (pt_rdata)
  );

  fps_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (s3_v_q),
    .waddr_i (s3_idx_q),
    .wdata_i (nmin_d),
    .raddr_i (raddr),
    .rdata_o (min_rdata)
  );

  always_comb begin
    tot_e  = CMPW'(point_total_q);
    want_e = (sample_count_q == '0) ? CMPW'(1) : CMPW'(sample_count_q);
    run_e  = (want_e < tot_e) ? want_e : tot_e;
    pk_e   = CMPW'(picked_total_q);
    st_e   = CMPW'(start_index_q);
    seq_mode = (want_e >= tot_e);
    if (seq_mode) begin
      direct_pick = picked_total_q[IW-1:0];
    end else if (st_e < tot_e) begin
      direct_pick = st_e[IW-1:0];
    end else begin
      direct_pick = '0;
    end
    is_last = ((pk_e + CMPW'(1)) == run_e);
  end

  assign stat_o.req_empty     = (point_total_q == '0);
  assign stat_o.req_exhausted = (pk_e >= run_e);
  assign stat_o.req_direct    = seq_mode || (picked_total_q == '0);
  assign stat_o.sweep_done    = !issuing_q && !rd_v_q && !s1_v_q && !s2_v_q
                                && !s3_v_q && !s4_v_q;

  // distance pipeline logic
  always_comb begin
    logic [C:0] dif;
    logic [C:0] neg;
    logic [2*C-1:0] ext;
    for (int k = 0; k < 3; k++) begin
      dif = {pt_rdata[k*C+C-1], pt_rdata[k*C +: C]} - {lp_q[k*C+C-1], lp_q[k*C +: C]};
      neg = ~dif + 1'b1;
      ad_d[k] = dif[C] ? neg[C-1:0] : dif[C-1:0];
      ext = {{C{1'b0}}, ad_q[k]};
      sq_d[k] = ext * ext;
    end
    dist_d = {2'b00, sq_q[0]} + {2'b00, sq_q[1]} + {2'b00, sq_q[2]};
    if (picked_total_q == CW'(1) || dist_q < s3_min_q) begin
      nmin_d = dist_q;
    end else begin
      nmin_d = s3_min_q;
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_out_coord
    if (C >= OUT_COORD_W) begin : g_trunc
      assign oc[g] = pt_rdata[g*C +: OUT_COORD_W];
    end else begin : g_sext
      assign oc[g] = {{(OUT_COORD_W-C){pt_rdata[g*C+C-1]}}, pt_rdata[g*C +: C]};
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= SAMPLE_COUNT_RST;
      start_index_q  <= START_INDEX_RST;
      point_total_q  <= '0;
      picked_total_q <= '0;
      last_picked_q  <= '0;
      overflow_q     <= 1'b0;
      scan_q         <= '0;
      issuing_q      <= 1'b0;
      rd_v_q         <= 1'b0;
      s1_v_q         <= 1'b0;
      s2_v_q         <= 1'b0;
      s3_v_q         <= 1'b0;
      s4_v_q         <= 1'b0;
      valid_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          CFG_SAMPLE_COUNT: sample_count_q <= cfg_wdata_i[SAMPLE_W-1:0];
          CFG_START_INDEX:  start_index_q  <= cfg_wdata_i[START_W-1:0];
        endcase
      end
      if (cmd_i.load) begin
        picked_total_q <= '0;
        if (new_set_i) begin
          overflow_q    <= 1'b0;
          point_total_q <= CW'(1);
        end else if (full) begin
          overflow_q <= 1'b1;
        end else begin
          point_total_q <= point_total_q + 1'b1;
        end
      end
      if (cmd_i.emit_pick) begin
        last_picked_q  <= pick_q;
        picked_total_q <= picked_total_q + 1'b1;
      end
      if (cmd_i.sweep_start) begin
        scan_q    <= '0;
        issuing_q <= 1'b1;
      end else if (issuing_q) begin
        scan_q <= scan_q + 1'b1;
        if ((scan_q + 1'b1) == point_total_q) begin
          issuing_q <= 1'b0;
        end
      end
      rd_v_q  <= issuing_q;
      s1_v_q  <= rd_v_q;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      s4_v_q  <= s3_v_q;
      valid_q <= cmd_i.emit_pick || cmd_i.emit_err;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_idx_q <= scan_q[IW-1:0];
    s1_idx_q <= rd_idx_q;
    s2_idx_q <= s1_idx_q;
    s3_idx_q <= s2_idx_q;
    s4_idx_q <= s3_idx_q;
    s1_min_q <= min_rdata;
    s2_min_q <= s1_min_q;
    s3_min_q <= s2_min_q;
    for (int k = 0; k < 3; k++) begin
      ad_q[k] <= ad_d[k];
      sq_q[k] <= sq_d[k];
    end
    dist_q <= dist_d;
    nmin_q <= nmin_d;
    if (s4_v_q && (s4_idx_q == '0 || nmin_q > best_q)) begin
      best_q     <= nmin_q;
      best_idx_q <= s4_idx_q;
    end
    if (cmd_i.lp_load) begin
      lp_q <= pt_rdata;
    end
    if (cmd_i.take_direct) begin
      pick_q <= direct_pick;
    end else if (cmd_i.pick_best) begin
      pick_q <= best_idx_q;
    end
    if (cmd_i.emit_pick) begin
      index_q  <= OIW'(pick_q);
      ox_q     <= oc[0];
      oy_q     <= oc[1];
      oz_q     <= oc[2];
      last_q   <= is_last;
      status_q <= STATUS_OK;
      ovf_q    <= overflow_q;
    end else if (cmd_i.emit_err) begin
      index_q  <= '0;
      ox_q     <= '0;
      oy_q     <= '0;
      oz_q     <= '0;
      last_q   <= 1'b0;
      status_q <= stat_o.req_empty ? STATUS_EMPTY : STATUS_DONE;
      ovf_q    <= overflow_q;
    end
  end

  assign valid_o       = valid_q;
  assign point_index_o = index_q;
  assign out_x_o       = ox_q;
  assign out_y_o       = oy_q;
  assign out_z_o       = oz_q;
  assign last_sample_o = last_q;
  assign status_o      = status_q;
  assign overflowed_o  = ovf_q;

endmodule

### rtl/fps_ctrl.sv
// controller state machine sequencing loads, sweeps and result words
module fps_ctrl import fps_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  input  logic  req_type_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  busy
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_RDLAST = 6'b000010,
    S_LPWAIT = 6'b000100,
    S_SWEEP  = 6'b001000,
    S_RDPICK = 6'b010000,
    S_EMIT   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          priority if (req_e'(req_type_i) == REQ_LOAD) begin
            cmd_o.load = 1'b1;
          end else if (stat_i.req_empty || stat_i.req_exhausted) begin
            cmd_o.emit_err = 1'b1;
          end else if (stat_i.req_direct) begin
            cmd_o.take_direct = 1'b1;
            state_d = S_RDPICK;
          end else begin
            state_d = S_RDLAST;
          end
        end
      end
      S_RDLAST: begin
        cmd_o.rd_last = 1'b1;
        state_d = S_LPWAIT;
      end
      S_LPWAIT: begin
        cmd_o.lp_load     = 1'b1;
        cmd_o.sweep_start = 1'b1;
        state_d = S_SWEEP;
      end
      S_SWEEP: begin
        if (stat_i.sweep_done) begin
          cmd_o.pick_best = 1'b1;
          state_d = S_RDPICK;
        end
      end
      S_RDPICK: begin
        cmd_o.rd_pick = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.emit_pick = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

### rtl/farthest_point_sampler.sv
// top level of the farthest point sampler: controller, datapath and self checks
//
// A word is taken at a rising edge with start high and busy low. req_type_i
// low loads one point (new_set_i clears the set first) and gives no result.
// req_type_i high asks for the next sample and gives exactly one result
// word, shown for one cycle with valid_o high.
// Error words (empty set, run finished) appear the cycle after acceptance
// and busy stays low. The first pick of a run, and every pick when the run
// covers the whole set, passes through the read-pick and emit states
// before its result word is registered. Any other pick sweeps all N loaded
// points through the distance pipeline, one point per cycle on the single
// read port of each store; busy is high meanwhile.
// Reset clears the counters, the overflow flag and the config registers to their
// defaults; the point and distance stores need no clearing pass since they
// are always written before read. The receiver cannot stall, so a result
// word is valid for one cycle only and is never held back.
`include "assert_macros.svh"

module farthest_point_sampler import fps_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          req_type_i,
  input  logic                          new_set_i,
  input  logic signed [COORD_BITS-1:0]  pos_x_i,
  input  logic signed [COORD_BITS-1:0]  pos_y_i,
  input  logic signed [COORD_BITS-1:0]  pos_z_i,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata_i,
  output logic                          valid_o,
  output logic [INDEX_OUT_W-1:0]        point_index_o,
  output logic signed [OUT_COORD_W-1:0] out_x_o,
  output logic signed [OUT_COORD_W-1:0] out_y_o,
  output logic signed [OUT_COORD_W-1:0] out_z_o,
  output logic                          last_sample_o,
  output logic [STATUS_W-1:0]           status_o,
  output logic                          overflowed_o
);

  cmd_t  cmd;
  stat_t stat;

  fps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_type_i (req_type_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy       (busy)
  );

  fps_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .new_set_i     (new_set_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .valid_o       (valid_o),
    .point_index_o (point_index_o),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .out_z_o       (out_z_o),
    .last_sample_o (last_sample_o),
    .status_o      (status_o),
    .overflowed_o  (overflowed_o)
  );

  // picks leave from the emit state, errors straight from idle
  `ASSERT_DEF(a_pick_after_busy, valid_o && status_o == STATUS_OK |-> $past(busy))
  `ASSERT_DEF(a_err_from_idle, valid_o && status_o != STATUS_OK |-> !$past(busy))
  `ASSERT_DEF(a_cmd_onehot, $onehot0({cmd.load, cmd.emit_err, cmd.take_direct, cmd.pick_best, cmd.emit_pick}))
  `ASSERT_DEF(a_sweep_idle_done, cmd.sweep_start |=> !stat.sweep_done)

endmodule

### verif/farthest_point_sampler_test.sv
// self-checking testbench of the farthest point sampler: queued stimulus, tracked picks
module farthest_point_sampler_test import fps_pkg::*;;

  localparam int STORE_DEPTH = MAX_POINTS_DEF;
  localparam int SETTLE      = 4;
  localparam int TAIL_CYCLES = 64;
  localparam int RAND_WORDS  = 140;

  typedef enum logic [1:0] {
    OP_WORD,
    OP_CFG,
    OP_DRAIN
  } op_e;

  typedef struct {
    op_e                    op;
    req_e                   kind;
    logic                   new_set;
    logic signed [15:0]     x;
    logic signed [15:0]     y;
    logic signed [15:0]     z;
    cfg_reg_e               sel;
    logic [CFG_DATA_W-1:0]  val;
  } pending_t;

  typedef struct packed {
    logic [INDEX_OUT_W-1:0] idx;
    logic [OUT_COORD_W-1:0] x;
    logic [OUT_COORD_W-1:0] y;
    logic [OUT_COORD_W-1:0] z;
    logic                   last;
    logic [STATUS_W-1:0]    st;
    logic                   ovf;
  } pick_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic                          req_type_i = 1'b0;
  logic                          new_set_i = 1'b0;
  logic signed [15:0]            pos_x_i = '0;
  logic signed [15:0]            pos_y_i = '0;
  logic signed [15:0]            pos_z_i = '0;
  logic                          cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]         cfg_wdata_i = '0;
  logic                          valid_o;
  logic [INDEX_OUT_W-1:0]        point_index_o;
  logic signed [OUT_COORD_W-1:0] out_x_o;
  logic signed [OUT_COORD_W-1:0] out_y_o;
  logic signed [OUT_COORD_W-1:0] out_z_o;
  logic                          last_sample_o;
  logic [STATUS_W-1:0]           status_o;
  logic                          overflowed_o;

  farthest_point_sampler dut (.*);

  always #1 clk_i = ~clk_i;

  // tracked copy of the block
  logic signed [15:0] pts_x [STORE_DEPTH];
  logic signed [15:0] pts_y [STORE_DEPTH];
  logic signed [15:0] pts_z [STORE_DEPTH];
  logic [63:0]        near_sq [STORE_DEPTH];
  int unsigned        stored_n = 0;
  int unsigned        picked_n = 0;
  int unsigned        prev_pick = 0;
  logic               drop_seen = 1'b0;
  logic [12:0]        want_samples = SAMPLE_COUNT_RST;
  logic [11:0]        first_pick = START_INDEX_RST;

  pending_t    pending [$];
  pick_t       expected_picks [$];
  pending_t    cur_word;
  int          words_queued = 0;
  int          words_sent = 0;
  int          samples_taken = 0;
  int          cfg_writes = 0;
  int          picks_checked = 0;
  int          bad_results = 0;
  int          gap_left = 0;
  int          calm_left = 0;
  int          quiet = 0;
  logic        stim_idle = 1'b0;

  function automatic logic [63:0] span_sq(int unsigned a, int unsigned b);
    longint dx, dy, dz;
    dx = longint'(pts_x[a]) - longint'(pts_x[b]);
    dy = longint'(pts_y[a]) - longint'(pts_y[b]);
    dz = longint'(pts_z[a]) - longint'(pts_z[b]);
    return 64'(dx * dx) + 64'(dy * dy) + 64'(dz * dz);
  endfunction

  task automatic step_picker(input pending_t w);
    pick_t       r;
    int unsigned want, run, pick, j;
    logic [63:0] d, best;
    if (w.kind == REQ_LOAD) begin
      if (w.new_set) begin
        stored_n = 0;
        drop_seen = 1'b0;
      end
      picked_n = 0;
      if (stored_n < STORE_DEPTH) begin
        pts_x[stored_n] = w.x;
        pts_y[stored_n] = w.y;
        pts_z[stored_n] = w.z;
        stored_n++;
      end else begin
        drop_seen = 1'b1;
      end
    end else begin
      samples_taken++;
      r = '0;
      r.ovf = drop_seen;
      r.st = STATUS_OK;
      want = (want_samples == 0) ? 1 : want_samples;
      run = (want < stored_n) ? want : stored_n;
      if (stored_n == 0) begin
        r.st = STATUS_EMPTY;
      end else if (picked_n >= run) begin
        r.st = STATUS_DONE;
      end else begin
        if (want >= stored_n) begin
          pick = picked_n;
        end else if (picked_n == 0) begin
          pick = (first_pick < stored_n) ? first_pick : 0;
        end else begin
          best = '0;
          pick = 0;
          for (j = 0; j < stored_n; j++) begin
            d = span_sq(prev_pick, j);
            if (picked_n == 1 || d < near_sq[j]) near_sq[j] = d;
            if (j == 0 || near_sq[j] > best) begin
              best = near_sq[j];
              pick = j;
            end
          end
        end
        prev_pick = pick;
        picked_n++;
        r.idx = pick[11:0];
        r.x = pts_x[pick];
        r.y = pts_y[pick];
        r.z = pts_z[pick];
        r.last = (picked_n == run);
      end
      expected_picks.push_back(r);
    end
  endtask

  function automatic logic signed [15:0] rand_coord();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 16'($urandom());
      5: begin
        case ($urandom_range(0, 3))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      default: begin
        v = $urandom_range(0, 4);
        return 16'(v - 2);
      end
    endcase
  endfunction

  function automatic logic [12:0] draw_count(int unsigned n);
    case ($urandom_range(0, 5))
      0: return 13'd0;
      1: return 13'($urandom_range(1, (n > 1) ? n - 1 : 1));
      2: return 13'($urandom_range(n, n + 3));
      3: return $urandom_range(0, 1) ? 13'd4096 : 13'd8191;
      default: return 13'($urandom_range(1, n));
    endcase
  endfunction

  task automatic add_load(input logic ns, input logic signed [15:0] x, y, z);
    pending_t p;
    p = '{op: OP_WORD, kind: REQ_LOAD, new_set: ns, x: x, y: y, z: z,
          sel: CFG_SAMPLE_COUNT, val: '0};
    pending.push_back(p);
    words_queued++;
  endtask

  task automatic add_sample();
    pending_t p;
    p = '{op: OP_WORD, kind: REQ_SAMPLE, new_set: 1'($urandom()), x: rand_coord(),
          y: rand_coord(), z: rand_coord(), sel: CFG_SAMPLE_COUNT, val: '0};
    pending.push_back(p);
    words_queued++;
  endtask

  task automatic add_cfg(input cfg_reg_e sel, input logic [CFG_DATA_W-1:0] val);
    pending_t p;
    p = '{op: OP_CFG, kind: REQ_LOAD, new_set: 1'b0, x: '0, y: '0, z: '0,
          sel: sel, val: val};
    pending.push_back(p);
  endtask

  task automatic add_drain();
    pending_t p;
    p = '{op: OP_DRAIN, kind: REQ_LOAD, new_set: 1'b0, x: '0, y: '0, z: '0,
          sel: CFG_SAMPLE_COUNT, val: '0};
    pending.push_back(p);
  endtask

  // driver
  always @(posedge clk_i) begin
    logic go, we;
    if (rst_ni) begin
      if (start && !busy) begin
        step_picker(cur_word);
        words_sent++;
      end
      if (start || busy || picks_checked != samples_taken) quiet = 0;
      else if (quiet < SETTLE) quiet++;
      go = start && busy;
      we = 1'b0;
      if (!go) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending.size() > 0) begin
          case (pending[0].op)
            OP_WORD: begin
              cur_word = pending.pop_front();
              req_type_i <= cur_word.kind;
              new_set_i <= cur_word.new_set;
              pos_x_i <= cur_word.x;
              pos_y_i <= cur_word.y;
              pos_z_i <= cur_word.z;
              go = 1'b1;
              if (calm_left > 0) begin
                calm_left--;
                gap_left = 0;
              end else begin
                case ($urandom_range(0, 19))
                  0, 1, 2, 3, 4, 5, 6, 7, 8, 9: gap_left = 0;
                  18, 19: gap_left = $urandom_range(10, 24);
                  default: gap_left = $urandom_range(1, 3);
                endcase
                if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(10, 40);
              end
            end
            OP_CFG: begin
              if (quiet >= SETTLE) begin
                cur_word = pending.pop_front();
                cfg_index_i <= cur_word.sel;
                cfg_wdata_i <= cur_word.val;
                we = 1'b1;
                cfg_writes++;
                if (cur_word.sel == CFG_SAMPLE_COUNT) want_samples = cur_word.val;
                else first_pick = cur_word.val[11:0];
              end
            end
            default: begin
              if (quiet >= SETTLE) void'(pending.pop_front());
            end
          endcase
        end
      end
      stim_idle = (pending.size() == 0) && !go;
      start <= go;
      cfg_we_i <= we;
    end
  end

  task automatic report_bad(input string what, input pick_t want, input pick_t got);
    bad_results++;
    if (bad_results <= 10) begin
      $display("%s: expected idx %0d xyz %h %h %h last %0b status %0d ovf %0b", what,
               want.idx, want.x, want.y, want.z, want.last, want.st, want.ovf);
      $display("  got idx %0d xyz %h %h %h last %0b status %0d ovf %0b",
               got.idx, got.x, got.y, got.z, got.last, got.st, got.ovf);
    end
  endtask

  // monitor
  always @(posedge clk_i) begin
    pick_t got, want;
    if (rst_ni && valid_o) begin
      got = {point_index_o, out_x_o, out_y_o, out_z_o, last_sample_o, status_o,
             overflowed_o};
      if (expected_picks.size() == 0) begin
        report_bad("result word with nothing pending", '0, got);
      end else begin
        want = expected_picks.pop_front();
        if (got !== want) report_bad("result word mismatch", want, got);
        picks_checked <= picks_checked + 1;
      end
    end
  end

  initial begin
    #800000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int unsigned set_n, n_req, k, base;
    logic [CFG_DATA_W-1:0] sv;

    // empty set, extremes, load order, then sweeps with restarts and odd registers
    add_sample();
    add_load(1'b1, -16'sd32768, -16'sd32768, -16'sd32768);
    add_load(1'b0, 16'sd32767, 16'sd32767, 16'sd32767);
    add_load(1'b0, 16'sd0, 16'sd0, 16'sd0);
    add_load(1'b0, -16'sd1, 16'sd1, -16'sd32768);
    add_load(1'b0, 16'sd32767, -16'sd32768, 16'sd0);
    repeat (6) add_sample();
    add_cfg(CFG_SAMPLE_COUNT, 13'd4);
    add_cfg(CFG_START_INDEX, 13'd1);
    add_load(1'b0, 16'sd0, 16'sd0, 16'sd0);
    repeat (5) add_sample();
    add_cfg(CFG_SAMPLE_COUNT, 13'd0);
    add_cfg(CFG_START_INDEX, 13'd4095);
    add_load(1'b1, 16'sd5, 16'sd5, 16'sd5);
    add_load(1'b0, -16'sd5, -16'sd5, -16'sd5);
    add_load(1'b0, 16'sd5, -16'sd5, 16'sd5);
    repeat (2) add_sample();
    add_cfg(CFG_SAMPLE_COUNT, 13'd2);
    add_cfg(CFG_START_INDEX, 13'd2);
    add_sample();
    add_cfg(CFG_SAMPLE_COUNT, 13'd8191);
    repeat (2) add_sample();
    add_drain();

    // fill the store past capacity
    add_cfg(CFG_SAMPLE_COUNT, 13'd4096);
    add_cfg(CFG_START_INDEX, 13'd0);
    add_load(1'b1, rand_coord(), rand_coord(), rand_coord());
    repeat (STORE_DEPTH) add_load(1'b0, rand_coord(), rand_coord(), rand_coord());
    repeat (3) add_sample();
    add_cfg(CFG_SAMPLE_COUNT, 13'd2);
    add_cfg(CFG_START_INDEX, 13'd4095);
    repeat (3) add_sample();
    add_load(1'b0, rand_coord(), rand_coord(), rand_coord());
    add_sample();
    add_drain();

    base = words_queued;
    while (words_queued < base + RAND_WORDS) begin
      set_n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      if ($urandom_range(0, 3) != 0) add_cfg(CFG_SAMPLE_COUNT, draw_count(set_n));
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 3))
          0: sv = 13'd4095;
          1: sv = 13'($urandom_range(set_n, 4095));
          default: sv = 13'($urandom_range(0, set_n - 1));
        endcase
        add_cfg(CFG_START_INDEX, sv);
      end
      for (k = 0; k < set_n; k++) add_load(k == 0, rand_coord(), rand_coord(), rand_coord());
      if ($urandom_range(0, 5) == 0) add_drain();
      n_req = $urandom_range(1, set_n + 2);
      for (k = 0; k < n_req; k++) begin
        if ($urandom_range(0, 15) == 0)
          add_load(1'b0, rand_coord(), rand_coord(), rand_coord());
        add_sample();
      end
      if ($urandom_range(0, 3) == 0) begin
        add_cfg(CFG_SAMPLE_COUNT, draw_count(set_n));
        repeat ($urandom_range(1, 4)) add_sample();
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (!stim_idle || picks_checked != samples_taken) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("%0d words driven, %0d sample requests, %0d result words checked",
             words_sent, samples_taken, picks_checked);
    $display("%0d register writes over empty, full and small point sets", cfg_writes);
    if (bad_results == 0 && expected_picks.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
